>>> rtl/tcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

   // Field widths of the channels, fixed by the console's item format.
   localparam int KIND_W      = 2;
   localparam int CHAR_W      = 8;
   localparam int ADDR_IN_W   = 11;
   localparam int LOC_W       = 11;
   localparam int CELL_W      = 16;
   localparam int COLOUR_W    = 4;
   localparam int CSR_INDEX_W = 1;

   // Default screen geometry.
   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   // Item kinds.
   localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_FORE_COLOUR = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACK_COLOUR = 1'd1;

   // Character codes with a meaning of their own.
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CH_LAST_TEXT = 8'h7F;

   localparam int TAB_STOP = 8;

   // White space on black.
   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

   localparam logic [COLOUR_W-1:0] FORE_RESET = 4'hF;
   localparam logic [COLOUR_W-1:0] BACK_RESET = 4'h0;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_COPY,
      ST_DRAIN,
      ST_BLANK_ROW,
      ST_CLEAR,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec_char;
      logic read_cell;
      logic home;
      logic sweep_zero;
      logic sweep_bottom;
      logic sweep_blank;
      logic copy_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              scroll_needed;
      logic              sweep_last;
      logic              copy_last;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/tcc_interfaces.sv
`timescale 1ns / 1ps
`default_nettype none

interface tcc_req_if import tcc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [CHAR_W-1:0]    char_code;
   logic [ADDR_IN_W-1:0] cell_address;

   modport source (output valid, output kind, output char_code, output cell_address,
                   input ready);
   modport sink   (input valid, input kind, input char_code, input cell_address,
                   output ready);
endinterface

interface tcc_rsp_if import tcc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [LOC_W-1:0]  cursor_location;
   logic [CELL_W-1:0] cell_data;

   modport source (output valid, output cursor_location, output cell_data, input ready);
   modport sink   (input valid, input cursor_location, input cell_data, output ready);
endinterface

interface tcc_csr_if import tcc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [COLOUR_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/text_console_cursor_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Text console of COLUMNS x ROWS character cells (80 x 25 by default), each cell holding an
// attribute byte over a character byte. A request beat carries a kind: a character byte is
// interpreted (backspace, tab, carriage return, line feed, printable text in the colours
// set through the register port, everything else ignored) with line wrap and a one-line
// scroll; a clear blanks the screen to white on black and homes the cursor; a read returns
// one cell. Every request gives exactly one response beat with the cursor location after
// it. Requests are handled one at a time, and a finished response waits in an output
// register while the next request is taken. The cells sit in one memory with a single
// write port, which sets the cost of the long operations: a clear and a character that
// scrolls each move or blank one cell per cycle. After reset the engine blanks the whole
// memory and accepts no request meanwhile; register writes are taken at any time.

module text_console_cursor_engine import tcc_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEFAULT,
   parameter int ROWS    = ROWS_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   tcc_req_if.sink   req_bus,
   tcc_rsp_if.source rsp_bus,
   tcc_csr_if.sink   csr_bus
);

   cmd_type    cmd;
   status_type status;

   // The colour registers are always ready; a beat on this port simply updates them.
   assign csr_bus.ready = 1'b1;

   // The controller sequences each request and owns the response valid; the datapath holds
   // the cursor, the line lengths, the cell memory and the response payload.
   tcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcc_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .item_kind       (req_bus.kind),
      .item_char       (req_bus.char_code),
      .item_address    (req_bus.cell_address),
      .csr_write       (csr_bus.valid),
      .csr_index       (csr_bus.index),
      .csr_data        (csr_bus.data),
      .cursor_location (rsp_bus.cursor_location),
      .cell_data       (rsp_bus.cell_data)
   );

endmodule

`default_nettype wire

>>> rtl/tcc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tcc_ctrl import tcc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            unique case (status.kind)
               KIND_CHAR: begin
                  if (status.scroll_needed) state_in = ST_COPY;
                  else if (slot_free)       state_in = ST_IDLE;
                  else                      state_in = ST_FINISH;
               end
               KIND_CLEAR: state_in = ST_CLEAR;
               KIND_READ:  state_in = ST_FINISH;
               default: begin
                  state_in = slot_free ? ST_IDLE : ST_FINISH;
               end
            endcase
         end
         ST_COPY: begin
            if (status.copy_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_BLANK_ROW;
         ST_BLANK_ROW, ST_CLEAR: begin
            if (status.sweep_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_INIT: cmd.sweep_blank = 1'b1;
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            unique case (status.kind)
               KIND_CHAR: begin
                  cmd.exec_char = 1'b1;
                  if (status.scroll_needed) cmd.sweep_zero = 1'b1;
                  else                      cmd.load_rsp   = slot_free;
               end
               KIND_CLEAR: begin
                  cmd.home       = 1'b1;
                  cmd.sweep_zero = 1'b1;
               end
               KIND_READ: cmd.read_cell = 1'b1;
               default:   cmd.load_rsp  = slot_free;
            endcase
         end
         ST_COPY:                cmd.copy_step    = 1'b1;
         ST_DRAIN:               cmd.sweep_bottom = 1'b1;
         ST_BLANK_ROW, ST_CLEAR: cmd.sweep_blank  = 1'b1;
         ST_FINISH:              cmd.load_rsp     = slot_free;
         default: ;
      endcase
   end

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken beat");

   a_drain_after_copy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> ($past(state_ff) == ST_COPY))
      else $error("drain entered without a copy pass");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("response beat withdrawn before it was taken");
`endif

endmodule

`default_nettype wire

>>> rtl/tcc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module tcc_datapath import tcc_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEFAULT,
   parameter int ROWS    = ROWS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output status_type                  status,
   input  wire logic [KIND_W-1:0]      item_kind,
   input  wire logic [CHAR_W-1:0]      item_char,
   input  wire logic [ADDR_IN_W-1:0]   item_address,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [COLOUR_W-1:0]    csr_data,
   output logic [LOC_W-1:0]            cursor_location,
   output logic [CELL_W-1:0]           cell_data
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int LW    = $clog2(COLUMNS + 1);
   localparam int TW    = $clog2(COLUMNS + TAB_STOP);

   // Captured item.
   logic [KIND_W-1:0]    kind_ff;
   logic [CHAR_W-1:0]    char_ff;
   logic [ADDR_IN_W-1:0] addr_ff;

   logic [COLOUR_W-1:0] fore_ff, back_ff;
   logic [CW-1:0]       col_ff, col_next;
   logic [RW-1:0]       row_ff, row_next;
   logic [LW-1:0]       len_ff [ROWS];

   logic [AW-1:0] sweep_ff;
   logic          copy_pend_ff;
   logic [AW-1:0] copy_addr_ff;

   logic [CELL_W-1:0] screen_mem [CELLS];
   logic [CELL_W-1:0] rd_data_ff;
   logic [LOC_W-1:0]  rsp_loc_ff;
   logic [CELL_W-1:0] rsp_data_ff;

   // Character interpretation.
   logic [TW-1:0]     col_t;
   logic [RW:0]       row_t;
   logic              rec_en;
   logic [LW-1:0]     rec_val;
   logic              put_en;
   logic [RW-1:0]     put_row;
   logic [CW-1:0]     put_col;
   logic [CHAR_W-1:0] put_char;
   logic [LW-1:0]     prev_len;

   assign prev_len = len_ff[row_ff - RW'(1)];

   always_comb begin
      col_t    = TW'(col_ff);
      row_t    = {1'b0, row_ff};
      rec_en   = 1'b0;
      rec_val  = LW'(col_ff);
      put_en   = 1'b0;
      put_row  = row_ff;
      put_col  = col_ff;
      put_char = char_ff;
      case (char_ff)
         CH_BACKSPACE: begin
            put_en   = 1'b1;
            put_char = CH_SPACE;
            if (col_ff != '0) begin
               col_t = TW'(col_ff) - TW'(1);
            end else if (row_ff != '0) begin
               row_t = {1'b0, row_ff - RW'(1)};
               col_t = (32'(prev_len) >= COLUMNS) ? TW'(COLUMNS - 1) : TW'(prev_len);
            end
            put_row = row_t[RW-1:0];
            put_col = col_t[CW-1:0];
         end
         CH_TAB: col_t = (TW'(col_ff) + TW'(TAB_STOP)) & ~TW'(TAB_STOP - 1);
         CH_CR:  col_t = '0;
         CH_LF: begin
            rec_en = 1'b1;
            col_t  = '0;
            row_t  = row_t + (RW + 1)'(1);
         end
         default: begin
            if (char_ff >= CH_SPACE && char_ff <= CH_LAST_TEXT) begin
               put_en = 1'b1;
               col_t  = TW'(col_ff) + TW'(1);
            end
         end
      endcase
      // Wrap onto the next line, recording how far this one ran.
      if (32'(col_t) >= COLUMNS) begin
         rec_en  = 1'b1;
         rec_val = (32'(col_t) > COLUMNS) ? LW'(COLUMNS) : LW'(col_t);
         col_t   = '0;
         row_t   = row_t + (RW + 1)'(1);
      end
   end

   assign col_next = col_t[CW-1:0];
   assign row_next = (32'(row_t) == ROWS) ? RW'(ROWS - 1) : row_t[RW-1:0];

   assign status.kind          = kind_ff;
   assign status.scroll_needed = (32'(row_t) == ROWS);
   assign status.sweep_last    = (sweep_ff == AW'(CELLS - 1));
   assign status.copy_last     = (sweep_ff == AW'((ROWS - 1) * COLUMNS - 1));

   // Memory port selection.
   logic              char_wr_en;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;

   assign char_wr_en = cmd.exec_char && put_en;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = sweep_ff;
      wr_data = BLANK_CELL;
      if (copy_pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = copy_addr_ff;
         wr_data = rd_data_ff;
      end else if (cmd.sweep_blank) begin
         wr_en = 1'b1;
      end else if (char_wr_en) begin
         wr_en   = 1'b1;
         wr_addr = AW'(put_row) * AW'(COLUMNS) + AW'(put_col);
         wr_data = {back_ff, fore_ff, put_char};
      end
   end

   assign rd_en   = cmd.copy_step || cmd.read_cell;
   assign rd_addr = cmd.copy_step ? (sweep_ff + AW'(COLUMNS)) : AW'(addr_ff);

   always_ff @(posedge clock) begin
      if (wr_en) screen_mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= screen_mem[rd_addr];
   end

   // Item capture and result payload.
   logic [RW-1:0]     loc_row;
   logic [CW-1:0]     loc_col;
   logic [AW-1:0]     loc_full;
   logic              addr_ok;

   assign loc_row  = cmd.exec_char ? row_next : row_ff;
   assign loc_col  = cmd.exec_char ? col_next : col_ff;
   assign loc_full = AW'(loc_row) * AW'(COLUMNS) + AW'(loc_col);
   assign addr_ok  = (32'(addr_ff) < CELLS);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= item_kind;
         char_ff <= item_char;
         addr_ff <= item_address;
      end
      if (cmd.load_rsp) begin
         rsp_loc_ff  <= LOC_W'(loc_full);
         rsp_data_ff <= (kind_ff == KIND_READ && addr_ok) ? rd_data_ff : '0;
      end
      if (cmd.copy_step) copy_addr_ff <= sweep_ff;
   end

   assign cursor_location = rsp_loc_ff;
   assign cell_data       = rsp_data_ff;

   // Cursor, line lengths, colours and the sweep counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         fore_ff      <= FORE_RESET;
         back_ff      <= BACK_RESET;
         sweep_ff     <= '0;
         copy_pend_ff <= 1'b0;
         for (int i = 0; i < ROWS; i++) len_ff[i] <= '0;
      end else begin
         copy_pend_ff <= cmd.copy_step;
         if (cmd.home) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (cmd.exec_char) begin
            col_ff <= col_next;
            row_ff <= row_next;
            if (rec_en) len_ff[row_ff] <= rec_val;
         end
         if (cmd.sweep_zero)                           sweep_ff <= '0;
         else if (cmd.sweep_bottom)                    sweep_ff <= AW'((ROWS - 1) * COLUMNS);
         else if (cmd.sweep_blank || cmd.copy_step)    sweep_ff <= sweep_ff + AW'(1);
         if (csr_write) begin
            unique case (csr_index)
               CSR_FORE_COLOUR: fore_ff <= csr_data;
               CSR_BACK_COLOUR: back_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

`ifndef SYNTHESIS
   a_write_port_free: assert property (@(posedge clock) disable iff (reset)
      copy_pend_ff |-> !(cmd.sweep_blank || char_wr_en))
      else $error("scroll copy write collides with another cell write");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(row_ff) < ROWS)
      else $error("cursor row beyond the screen");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) < COLUMNS)
      else $error("cursor column beyond the screen");
`endif

endmodule

`default_nettype wire
